/* hdl/knn_pkg.sv */
// knn_pkg: shared types and constants for the k-nearest-neighbor stencil builder
// used by the front, back and top level modules; depends on nothing

package knn_pkg;

    // fixed field widths
    localparam int IDX_W   = 10;
    localparam int DIST_W  = 25;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 11;
    localparam int K_W     = 7;
    localparam int DIM_W   = 2;
    localparam int SIZE_W  = 6;
    localparam int SUM_W   = 32;
    localparam int DSTEP_W = 5;

    // apb port
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes
    localparam logic [1:0] REG_STENCIL = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_DIMS    = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0] STENCIL_RST = 6'd32;
    localparam logic [CNT_W-1:0]  COUNT_RST   = 11'd1024;
    localparam logic [DIM_W-1:0]  DIMS_RST    = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_SINGLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] index;
    } cmd_hdr_t;

    // effective configuration seen by the back end
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [K_W-1:0]   k;
        logic [DIM_W-1:0] dims;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  neighbor_index;
        logic [DIST_W-1:0] neighbor_distance;
        logic [DIST_W-1:0] average_distance;
        logic [STAT_W-1:0] status;
        logic              last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CWAIT,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_EMIT,
        S_SUM,
        S_DIV,
        S_FINAL
    } knn_state_t;

endpackage

/* hdl/knn_ram.sv */
// knn_ram: generic single write, single read memory with registered read data
// no dependencies

module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/knn_fifo.sv */
// knn_fifo: small register-based queue with push/full and pop/empty sides
// no dependencies

module knn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == FW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_reg];

    // pointer and fill update
    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_reg] <= wdata;
        end
    end

endmodule

/* hdl/knn_front.sv */
// knn_front: configuration registers, input transaction classification and
// command queue; depends on knn_pkg and knn_fifo

module knn_front
    import knn_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 32,
    parameter int COORD_BITS    = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    // input transactions
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic [IDX_W-1:0]          point_index,
    input  logic [COORD_BITS-1:0]     coord_x,
    input  logic [COORD_BITS-1:0]     coord_y,
    input  logic [COORD_BITS-1:0]     coord_z,
    // to back end
    output cfg_t                      cfg,
    output logic                      cmd_empty,
    input  logic                      cmd_pop,
    output cmd_hdr_t                  cmd_hdr,
    output logic [3*COORD_BITS-1:0]   cmd_coord
);

    localparam int CMD_W = $bits(cmd_hdr_t) + 3 * COORD_BITS;

    logic [SIZE_W-1:0] stencil_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DIM_W-1:0]  dims_reg;
    logic              cfg_wr;
    logic [CNT_W-1:0]  count_eff;
    logic [11:0]       k_a;
    cmd_hdr_t          hdr_in;
    logic              drop;
    logic [CMD_W-1:0]  cmd_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stencil_reg <= STENCIL_RST;
            count_reg   <= COUNT_RST;
            dims_reg    <= DIMS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_STENCIL: stencil_reg <= pwdata[SIZE_W-1:0];
                REG_COUNT:   count_reg   <= pwdata[CNT_W-1:0];
                REG_DIMS:    dims_reg    <= pwdata[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            REG_STENCIL: prdata = DATA_W'(stencil_reg);
            REG_COUNT:   prdata = DATA_W'(count_reg);
            REG_DIMS:    prdata = DATA_W'(dims_reg);
            default:     prdata = '0;
        endcase
    end

    // effective count, neighbor count and dimensions
    always_comb
    begin
        count_eff = count_reg;
        if (32'(count_reg) > MAX_POINTS)
        begin
            count_eff = CNT_W'(MAX_POINTS);
        end
        if (count_eff == '0)
        begin
            count_eff = CNT_W'(1);
        end
        k_a = 12'(stencil_reg);
        if (k_a == '0)
        begin
            k_a = 12'd1;
        end
        if (k_a > 12'(MAX_NEIGHBORS))
        begin
            k_a = 12'(MAX_NEIGHBORS);
        end
        if (k_a > 12'(count_eff))
        begin
            k_a = 12'(count_eff[CNT_W-1:1]);
            if (k_a == '0)
            begin
                k_a = 12'd1;
            end
        end
    end

    assign cfg.count = count_eff;
    assign cfg.k     = K_W'(k_a);
    assign cfg.dims  = (dims_reg == '0) ? DIM_W'(1) : dims_reg;

    // classify the incoming transaction
    always_comb
    begin
        hdr_in.index = point_index;
        if (!mode)
        begin
            hdr_in.kind = CMD_LOAD;
        end
        else if (CNT_W'(point_index) >= count_eff)
        begin
            hdr_in.kind = CMD_BAD;
        end
        else
        begin
            hdr_in.kind = CMD_QUERY;
        end
    end

    // loads beyond the store are accepted and dropped
    assign drop     = !mode && (32'(point_index) >= MAX_POINTS);
    assign cmd_word = {hdr_in, coord_z, coord_y, coord_x};

    knn_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !drop),
        .wdata (cmd_word),
        .full  (full),
        .pop   (cmd_pop),
        .rdata ({cmd_hdr, cmd_coord}),
        .empty (cmd_empty)
    );

endmodule

/* hdl/knn_back.sv */
// knn_back: point store, distance scan with sorted insertion, bit-serial
// square root and divider, result generation; depends on knn_pkg and knn_ram

module knn_back
    import knn_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 32,
    parameter int COORD_BITS    = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    cmd_empty,
    output logic                    cmd_pop,
    input  cmd_hdr_t                cmd_hdr,
    input  logic [3*COORD_BITS-1:0] cmd_coord,
    input  logic                    res_full,
    output logic                    res_push,
    output res_t                    res
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW     = COORD_BITS;
    localparam int R_W    = CW + 1;
    localparam int D_W    = 2 * R_W;
    localparam int STEP_W = $clog2(R_W);
    localparam int NB     = MAX_NEIGHBORS;
    localparam int NB1    = (NB > 1) ? 1 : 0;

    knn_state_t state_reg, state_next;

    logic [AW-1:0]      ram_raddr;
    logic [3*CW-1:0]    ram_rdata;
    logic               ram_we;

    logic [IDX_W-1:0]   center_reg;
    logic [K_W-1:0]     k_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIM_W-1:0]   dims_reg;
    logic [CNT_W-1:0]   j_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;

    // scan pipeline
    logic               v_rd_reg, v_df_reg, v_sq_reg, v_d_reg;
    logic [IDX_W-1:0]   j_rd_reg, j_df_reg, j_sq_reg, j_d_reg;
    logic [R_W-1:0]     dx_reg, dy_reg, dz_reg;
    logic [D_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [D_W-1:0]     d_reg;

    // best list
    logic [D_W-1:0]     list_d_reg [NB];
    logic [IDX_W-1:0]   list_i_reg [NB];

    // square root unit
    logic [D_W-1:0]     rad_reg;
    logic [R_W+2:0]     rem_reg;
    logic [R_W-1:0]     root_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [R_W+2:0]     rem_s, trial;
    logic               root_ge;
    logic [DIST_W-1:0]  dist_sat;

    // divider unit
    logic [K_W-1:0]     r_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   dvd_reg;
    logic [K_W:0]       drem_reg;
    logic [DSTEP_W-1:0] dstep_reg;
    logic [K_W:0]       drem_s, divisor;
    logic               div_ge;
    logic [DIST_W-1:0]  avg_sat;

    logic               cmd_ok;
    logic               scan_end, root_end, root_last, drain_done;
    logic signed [CW:0] ex, ey, ez;

    // point store, x in the low bits
    knn_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd_hdr.index)),
        .wdata (cmd_coord),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ok     = !cmd_empty;
    assign scan_end   = (j_reg == cnt_reg - CNT_W'(1));
    assign root_end   = (step_reg == STEP_W'(R_W - 1));
    assign root_last  = (r_reg == k_reg - K_W'(1));
    assign drain_done = !(v_rd_reg || v_df_reg || v_sq_reg || v_d_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_ok && (cmd_hdr.kind == CMD_QUERY))
                begin
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT: state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_end)
                begin
                    state_next = root_last ? S_SUM : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = S_ROOT;
                end
            end
            S_SUM: state_next = (k_reg == K_W'(1)) ? S_FINAL : S_DIV;
            S_DIV:
            begin
                if (dstep_reg == DSTEP_W'(SUM_W - 1))
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // saturated root and average
    assign dist_sat = (64'(root_reg) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_reg);
    assign avg_sat  = (64'(dvd_reg) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(dvd_reg);

    // control outputs and result payload
    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_we    = 1'b0;
        res_push  = 1'b0;
        ram_raddr = AW'(j_reg);
        res       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = AW'(cmd_hdr.index);
                if (cmd_ok)
                begin
                    unique case (cmd_hdr.kind)
                        CMD_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            ram_we  = 1'b1;
                        end
                        CMD_QUERY: cmd_pop = 1'b1;
                        CMD_BAD:
                        begin
                            cmd_pop    = !res_full;
                            res_push   = !res_full;
                            res.status = ST_RANGE;
                            res.last   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT:
            begin
                res_push              = !res_full;
                res.neighbor_index    = list_i_reg[0];
                res.neighbor_distance = dist_sat;
            end
            S_FINAL:
            begin
                res_push              = !res_full;
                res.neighbor_index    = list_i_reg[0];
                res.neighbor_distance = dist_sat;
                res.last              = 1'b1;
                if (k_reg == K_W'(1))
                begin
                    res.status = ST_SINGLE;
                end
                else
                begin
                    res.average_distance = avg_sat;
                end
            end
            default: ;
        endcase
    end

    // square root step
    always_comb
    begin
        rem_s   = {rem_reg[R_W:0], rad_reg[D_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        root_ge = (rem_s >= trial);
    end

    // divide step
    always_comb
    begin
        drem_s  = {drem_reg[K_W-1:0], dvd_reg[SUM_W-1]};
        divisor = {1'b0, k_reg - K_W'(1)};
        div_ge  = (drem_s >= divisor);
    end

    // signed differences of the point under test against the center
    always_comb
    begin
        ex = $signed({ram_rdata[CW-1], ram_rdata[CW-1:0]}) - $signed({cx_reg[CW-1], cx_reg});
        ey = $signed({ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]})
           - $signed({cy_reg[CW-1], cy_reg});
        ez = $signed({ram_rdata[3*CW-1], ram_rdata[3*CW-1:2*CW]})
           - $signed({cz_reg[CW-1], cz_reg});
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v_rd_reg  <= 1'b0;
            v_df_reg  <= 1'b0;
            v_sq_reg  <= 1'b0;
            v_d_reg   <= 1'b0;
            j_reg     <= '0;
            step_reg  <= '0;
            dstep_reg <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_rd_reg  <= (state_reg == S_SCAN) && (j_reg != CNT_W'(center_reg));
            v_df_reg  <= v_rd_reg;
            v_sq_reg  <= v_df_reg;
            v_d_reg   <= v_sq_reg;
            if (state_reg == S_CWAIT)
            begin
                j_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                j_reg <= j_reg + CNT_W'(1);
            end
            if (state_reg == S_ROOT)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == S_DIV)
            begin
                dstep_reg <= dstep_reg + DSTEP_W'(1);
            end
            else
            begin
                dstep_reg <= '0;
            end
            if (state_reg == S_DRAIN)
            begin
                r_reg <= '0;
            end
            else if ((state_reg == S_EMIT) && !res_full)
            begin
                r_reg <= r_reg + K_W'(1);
            end
        end
    end

    // query setup and center capture
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && cmd_ok && (cmd_hdr.kind == CMD_QUERY))
        begin
            center_reg <= cmd_hdr.index;
            k_reg      <= cfg.k;
            cnt_reg    <= cfg.count;
            dims_reg   <= cfg.dims;
        end
        if (state_reg == S_CWAIT)
        begin
            cx_reg <= ram_rdata[CW-1:0];
            cy_reg <= ram_rdata[2*CW-1:CW];
            cz_reg <= ram_rdata[3*CW-1:2*CW];
        end
    end

    // distance pipeline: abs difference, square, sum
    always_ff @(posedge clk)
    begin
        j_rd_reg <= IDX_W'(j_reg);
        j_df_reg <= j_rd_reg;
        j_sq_reg <= j_df_reg;
        j_d_reg  <= j_sq_reg;
        dx_reg   <= ex[CW] ? R_W'(-ex) : R_W'(ex);
        dy_reg   <= (dims_reg >= DIM_W'(2)) ? (ey[CW] ? R_W'(-ey) : R_W'(ey)) : '0;
        dz_reg   <= (dims_reg >= DIM_W'(3)) ? (ez[CW] ? R_W'(-ez) : R_W'(ez)) : '0;
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
        sz_reg   <= dz_reg * dz_reg;
        d_reg    <= sx_reg + sy_reg + sz_reg;
    end

    // best list: init, sorted insertion, shift out
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CWAIT)
        begin
            list_d_reg[0] <= '0;
            list_i_reg[0] <= center_reg;
            for (int m = 1; m < NB; m++)
            begin
                list_d_reg[m] <= '1;
                list_i_reg[m] <= '0;
            end
        end
        else if (v_d_reg)
        begin
            for (int m = 1; m < NB; m++)
            begin
                if (list_d_reg[m] > d_reg)
                begin
                    if ((m > 1) && (list_d_reg[m-1] > d_reg))
                    begin
                        list_d_reg[m] <= list_d_reg[m-1];
                        list_i_reg[m] <= list_i_reg[m-1];
                    end
                    else
                    begin
                        list_d_reg[m] <= d_reg;
                        list_i_reg[m] <= j_d_reg;
                    end
                end
            end
        end
        else if ((state_reg == S_EMIT) && !res_full)
        begin
            for (int m = 0; m < NB - 1; m++)
            begin
                list_d_reg[m] <= list_d_reg[m+1];
                list_i_reg[m] <= list_i_reg[m+1];
            end
        end
    end

    // square root and divider datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DRAIN) || ((state_reg == S_EMIT) && !res_full))
        begin
            rad_reg  <= (state_reg == S_DRAIN) ? list_d_reg[0] : list_d_reg[NB1];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == S_ROOT)
        begin
            rad_reg  <= {rad_reg[D_W-3:0], 2'b00};
            rem_reg  <= root_ge ? (rem_s - trial) : rem_s;
            root_reg <= {root_reg[R_W-2:0], root_ge};
        end
        if (state_reg == S_DRAIN)
        begin
            sum_reg <= '0;
        end
        else if ((state_reg == S_EMIT) && !res_full)
        begin
            sum_reg <= sum_reg + SUM_W'(dist_sat);
        end
        if (state_reg == S_SUM)
        begin
            dvd_reg  <= sum_reg + SUM_W'(dist_sat);
            drem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            drem_reg <= div_ge ? (drem_s - divisor) : drem_s;
            dvd_reg  <= {dvd_reg[SUM_W-2:0], div_ge};
        end
    end

endmodule

/* hdl/knn_stencil_builder_top.sv */
// Load transaction: stored when the back end pops it from the command queue, no result.
// Query: a scan over the point set, then per stencil member a bit-serial root plus an emit;
// the last member swaps its emit for a sum step, a divide (skipped for a one-member stencil)
// and a final step; one query at a time. Out-of-range center: one result, pushed in the
// same cycle that the back end pops the command. Reset: neighbor count 32, point count 1024,
// dimensions 2, queues empty, point store undefined; uses knn_pkg, front, back, fifo.

module knn_stencil_builder_top
    import knn_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 32,
    parameter int COORD_BITS    = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic                  mode,
    input  logic [IDX_W-1:0]      point_index,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic [COORD_BITS-1:0] coord_z,
    output logic                  empty,
    input  logic                  pop,
    output logic [IDX_W-1:0]      neighbor_index,
    output logic [DIST_W-1:0]     neighbor_distance,
    output logic [DIST_W-1:0]     average_distance,
    output logic [STAT_W-1:0]     status,
    output logic                  last
);

    cfg_t                    cfg;
    cmd_hdr_t                cmd_hdr;
    logic [3*COORD_BITS-1:0] cmd_coord;
    logic                    cmd_empty, cmd_pop;
    logic                    res_full, res_push;
    res_t                    res_in, res_out;

    // front end: registers, classification, command queue
    knn_front #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cfg         (cfg),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cmd_hdr     (cmd_hdr),
        .cmd_coord   (cmd_coord)
    );

    // back end: store, scan, root, divide
    knn_back #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_hdr   (cmd_hdr),
        .cmd_coord (cmd_coord),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    knn_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign neighbor_index    = res_out.neighbor_index;
    assign neighbor_distance = res_out.neighbor_distance;
    assign average_distance  = res_out.average_distance;
    assign status            = res_out.status;
    assign last              = res_out.last;

endmodule

/* tb/sv/knn_stencil_builder_top_tb.sv */
`timescale 1ns / 100ps
// knn_stencil_builder_top_tb: self-checking bench for the k-nearest-neighbor stencil builder
// loads points, runs queries over several register settings, predicts every stencil
// depends on knn_pkg and knn_stencil_builder_top

module knn_stencil_builder_top_tb;
    import knn_pkg::*;

    localparam int NPTS      = 1024;
    localparam int NBR_MAX   = 32;
    localparam int CYCLE_CAP = 1000000;
    localparam int HOLD_LEN  = 4000;
    localparam int IDLE_WAIT = 40;
    localparam bit MODE_LOAD  = 1'b0;
    localparam bit MODE_QUERY = 1'b1;

    typedef struct {
        bit        mode;
        bit [9:0]  idx;
        bit [23:0] x;
        bit [23:0] y;
        bit [23:0] z;
    } txn_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic                  mode;
    logic [IDX_W-1:0]      point_index;
    logic [23:0]           coord_x;
    logic [23:0]           coord_y;
    logic [23:0]           coord_z;
    logic                  empty;
    logic                  pop;
    logic [IDX_W-1:0]      neighbor_index;
    logic [DIST_W-1:0]     neighbor_distance;
    logic [DIST_W-1:0]     average_distance;
    logic [STAT_W-1:0]     status;
    logic                  last;

    // pending stimulus and expected stencil members
    txn_t pending_txns[$];
    res_t stencil_expect[$];
    int   mismatches = 0;
    int   cycles = 0;

    // predictor state
    bit signed [23:0] pt_x[NPTS];
    bit signed [23:0] pt_y[NPTS];
    bit signed [23:0] pt_z[NPTS];
    bit [5:0]         cfg_size  = STENCIL_RST;
    bit [10:0]        cfg_count = COUNT_RST;
    bit [1:0]         cfg_dims  = DIMS_RST;

    // generator view of which points hold data
    bit gen_loaded[NPTS];

    // driver / receiver control
    bit took;
    int burst_left = 4;
    int gap_left   = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_cnt   = 0;
    int stall_kind = 0;
    int stall_age  = 0;

    knn_stencil_builder_top dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sq_span(input int a, input int b, input int dims);
        longint d;
        longint unsigned s;
        d = longint'(pt_x[a]) - longint'(pt_x[b]);
        if (d < 0) d = -d;
        s = d * d;
        if (dims >= 2)
        begin
            d = longint'(pt_y[a]) - longint'(pt_y[b]);
            if (d < 0) d = -d;
            s = s + d * d;
        end
        if (dims >= 3)
        begin
            d = longint'(pt_z[a]) - longint'(pt_z[b]);
            if (d < 0) d = -d;
            s = s + d * d;
        end
        return s;
    endfunction

    // expected stencil for one query transaction
    function automatic void predict_stencil(input int ctr);
        int              cnt;
        int              k;
        int              dims;
        int              filled;
        int              pos;
        longint unsigned d;
        longint unsigned root;
        longint unsigned sum;
        longint unsigned avg;
        longint unsigned best_d[NBR_MAX];
        int              best_i[NBR_MAX];
        res_t            r;
        cnt = (cfg_count > NPTS) ? NPTS : cfg_count;
        if (cnt == 0) cnt = 1;
        k = (cfg_size == 0) ? 1 : cfg_size;
        if (k > NBR_MAX) k = NBR_MAX;
        if (k > cnt) k = (cnt / 2 < 1) ? 1 : cnt / 2;
        dims = (cfg_dims == 0) ? 1 : cfg_dims;
        if (ctr >= cnt)
        begin
            r = '0;
            r.status = ST_RANGE;
            r.last = 1'b1;
            stencil_expect.insert(stencil_expect.size(), r);
            return;
        end
        foreach (best_d[m])
        begin
            best_d[m] = '1;
            best_i[m] = 0;
        end
        best_i[0] = ctr;
        best_d[0] = 0;
        filled = 1;
        for (int j = 0; j < cnt; j++)
        begin
            if (j == ctr) continue;
            d = sq_span(ctr, j, dims);
            if (filled == k && (k == 1 || d >= best_d[k-1])) continue;
            pos = filled;
            while (pos > 1 && best_d[pos-1] > d)
                pos--;
            if (filled < k) filled++;
            for (int m = filled - 1; m > pos; m--)
            begin
                best_d[m] = best_d[m-1];
                best_i[m] = best_i[m-1];
            end
            best_d[pos] = d;
            best_i[pos] = j;
        end
        sum = 0;
        for (int m = 0; m < k; m++)
        begin
            root = int_sqrt(best_d[m]);
            if (root > DIST_MAX) root = DIST_MAX;
            sum = sum + root;
            r = '0;
            r.neighbor_index = IDX_W'(best_i[m]);
            r.neighbor_distance = DIST_W'(root);
            if (m == k - 1)
            begin
                r.last = 1'b1;
                if (k == 1)
                    r.status = ST_SINGLE;
                else
                begin
                    avg = sum / (k - 1);
                    r.average_distance = (avg > DIST_MAX) ? DIST_MAX : DIST_W'(avg);
                end
            end
            stencil_expect.insert(stencil_expect.size(), r);
        end
    endfunction

    // accept transactions and update the predictor
    always @(posedge clk)
    begin
        took = 1'b0;
        if (rst_n && push && !full)
        begin
            took = 1'b1;
            void'(pending_txns.pop_front());
            if (mode == MODE_LOAD)
            begin
                pt_x[point_index] = coord_x;
                pt_y[point_index] = coord_y;
                pt_z[point_index] = coord_z;
            end
            else
                predict_stencil(int'(point_index));
        end
    end

    // driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n || (push && !took))
            ;
        else if (gap_left > 0)
        begin
            push <= 1'b0;
            gap_left--;
        end
        else if (pending_txns.size() > 0)
        begin
            push        <= 1'b1;
            mode        <= pending_txns[0].mode;
            point_index <= pending_txns[0].idx;
            coord_x     <= pending_txns[0].x;
            coord_y     <= pending_txns[0].y;
            coord_z     <= pending_txns[0].z;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 30);
                case ($urandom_range(0, 7))
                    0, 1, 2: gap_left = 0;
                    7:       gap_left = $urandom_range(10, 40);
                    default: gap_left = $urandom_range(1, 5);
                endcase
            end
            else
                burst_left--;
        end
        else
            push <= 1'b0;
    end

    // receiver: stall pattern plus requested long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_LEN;
            pop       <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            pop      <= 1'b0;
        end
        else
        begin
            if (stall_age == 0)
            begin
                stall_kind = $urandom_range(0, 3);
                stall_age  = $urandom_range(8, 80);
            end
            else
                stall_age--;
            case (stall_kind)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 1) == 1);
                2:       pop <= ($urandom_range(0, 9) == 0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // monitor: compare each popped transaction with the oldest expectation
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && pop && !empty)
        begin
            if (stencil_expect.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, index %0d", $time, neighbor_index);
            end
            else
            begin
                e = stencil_expect.pop_front();
                if (neighbor_index !== e.neighbor_index)
                begin
                    mismatches++;
                    $display("%0t: neighbor_index expected %0d actual %0d", $time,
                             e.neighbor_index, neighbor_index);
                end
                if (neighbor_distance !== e.neighbor_distance)
                begin
                    mismatches++;
                    $display("%0t: neighbor_distance expected %0d actual %0d", $time,
                             e.neighbor_distance, neighbor_distance);
                end
                if (average_distance !== e.average_distance)
                begin
                    mismatches++;
                    $display("%0t: average_distance expected %0d actual %0d", $time,
                             e.average_distance, average_distance);
                end
                if (status !== e.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                end
                if (last !== e.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0d actual %0d", $time, e.last, last);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input int unsigned val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_STENCIL: cfg_size  = val[5:0];
            REG_COUNT:   cfg_count = val[10:0];
            default:     cfg_dims  = val[1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int unsigned sz, input int unsigned cnt, input int unsigned dm);
        reg_write(REG_STENCIL, sz);
        reg_write(REG_COUNT, cnt);
        reg_write(REG_DIMS, dm);
    endtask

    // wait until every transaction is taken and every result has come
    task automatic drain_all();
        while (pending_txns.size() != 0 || stencil_expect.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic add_load(input int idx, input bit [23:0] x, input bit [23:0] y,
                            input bit [23:0] z);
        txn_t t;
        t.mode = MODE_LOAD;
        t.idx  = 10'(idx);
        t.x    = x;
        t.y    = y;
        t.z    = z;
        gen_loaded[idx] = 1'b1;
        pending_txns.insert(pending_txns.size(), t);
    endtask

    task automatic add_query(input int idx);
        txn_t t;
        t.mode = MODE_QUERY;
        t.idx  = 10'(idx);
        t.x    = 24'($urandom);
        t.y    = 24'($urandom);
        t.z    = 24'($urandom);
        pending_txns.insert(pending_txns.size(), t);
    endtask

    // full range or a small cluster, the latter to force distance ties
    function automatic bit [23:0] rand_coord();
        if ($urandom_range(0, 2) == 0)
            return 24'($signed($urandom_range(0, 6)) - 3) << 18;
        return 24'($urandom);
    endfunction

    task automatic add_rand_load(input int idx);
        add_load(idx, rand_coord(), rand_coord(), rand_coord());
    endtask

    // make sure every point that a scan will read holds data
    task automatic fill_points(input int cnt);
        for (int i = 0; i < cnt; i++)
            if (!gen_loaded[i] || $urandom_range(0, 5) == 0)
                add_rand_load(i);
    endtask

    function automatic int eff_count();
        int c;
        c = (cfg_count > NPTS) ? NPTS : cfg_count;
        return (c == 0) ? 1 : c;
    endfunction

    initial
    begin
        int cnt;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        pop = 1'b0;
        mode = 1'b0;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, ties, center at zero distance, out of range
        configure(4, 8, 3);
        add_load(0, 24'h800000, 24'h7FFFFF, 24'h000000);
        add_load(1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
        add_load(2, 24'h800000, 24'h7FFFFF, 24'h000000);
        add_load(3, 24'h000000, 24'h000000, 24'h7FFFFF);
        add_load(4, 24'h000010, 24'h000000, 24'h000000);
        add_load(5, 24'hFFFFF0, 24'h000000, 24'h000000);
        add_load(6, 24'h000000, 24'h000010, 24'h000000);
        add_load(7, 24'h000000, 24'h000000, 24'h800000);
        add_load(1023, 24'h555555, 24'hAAAAAA, 24'h123456);
        add_query(0);
        add_query(7);
        add_query(3);
        add_query(8);
        add_query(1023);
        drain_all();
        configure(1, 8, 0);
        add_query(4);
        drain_all();
        configure(0, 8, 1);
        add_query(4);
        drain_all();
        configure(63, 8, 2);
        add_query(6);
        add_query(2);
        drain_all();
        configure(5, 0, 3);
        add_query(0);
        add_query(1);
        drain_all();

        // random phases with small point sets
        for (int ph = 0; ph < 8; ph++)
        begin
            cnt = (ph == 3) ? 2 : $urandom_range(2, 48);
            configure($urandom_range(0, 63), cnt, $urandom_range(0, 3));
            fill_points(eff_count());
            if (ph == 5)
                hold_req++;
            for (int n = 0; n < 33; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_rand_load($urandom_range(0, 1023));
                else if ($urandom_range(0, 9) == 0)
                    add_query($urandom_range(eff_count(), 1023));
                else
                    add_query($urandom_range(0, eff_count() - 1));
            end
            drain_all();
        end

        if (mismatches == 0 && stencil_expect.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
